FILE: hdl/pdfa_pkg.sv
package pdfa_pkg;

  // port field widths
  localparam int MODE_W  = 2;
  localparam int NODE_W  = 8;
  localparam int SYM_W   = 4;
  localparam int CNT_W   = 24;
  localparam int PROB_W  = 33;

  // probability 1.0 in unsigned Q1.32
  localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {(PROB_W-1){1'b0}}};

  // default sizes of the automaton tables
  localparam int NODE_COUNT_DEF    = 256;
  localparam int ALPHABET_SIZE_DEF = 16;
  localparam int COUNT_BITS_DEF    = 24;

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_NODE = 2'd0,
    MODE_LOAD_EDGE = 2'd1,
    MODE_SYMBOL    = 2'd2,
    MODE_END       = 2'd3
  } mode_t;

endpackage

FILE: hdl/pdfa_trace_scorer.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_ready  | mode node_index symbol count_value
//          |           |                      | final_count target_node
// out      | output    | out_valid/out_ready  | probability rejected
// cfg      | input     | cfg_valid/cfg_ready  | cfg_data (root node)
//
// A load is written to its table as it is taken. A symbol that is ignored or rejected is
// looked up and then dropped; a symbol that scales the probability waits on the shared
// scaling unit (one multiply, then 33 radix-2 division steps), which skips the division
// when the product already saturates. An end item does the same, then enters the output
// register. After reset all NODE_COUNT*ALPHABET_SIZE edge counts (4096 by default) are
// cleared, one entry a cycle; no item is taken meanwhile, configuration writes are.
// A result waiting on out_ready does not block new items; a second end item waits
// until the output register is free.
module pdfa_trace_scorer
  import pdfa_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [NODE_W-1:0] node_index,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [CNT_W-1:0]  count_value,
  input  logic [CNT_W-1:0]  final_count,
  input  logic [NODE_W-1:0] target_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PROB_W-1:0] probability,
  output logic              rejected,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NODE_W-1:0] cfg_data
);

  localparam int EDGE_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int NA_W       = $clog2(NODE_COUNT);
  localparam int EA_W       = $clog2(EDGE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                state;
  mode_t                 item_mode;
  logic [SYM_W-1:0]      item_sym;
  logic [NODE_W-1:0]     root_node;
  logic [NODE_W-1:0]     current_node;
  logic [PROB_W-1:0]     running_prob;
  logic                  walk_failed;
  logic [NODE_W-1:0]     next_node;
  logic [PROB_W-1:0]     res_prob;
  logic                  res_rej;

  logic                  cleared;
  logic                  in_xfer;
  logic                  out_free;
  logic                  load_node_ok;
  logic                  load_sym_ok;
  logic                  walk_node_ok;
  logic                  walk_sym_ok;
  logic [COUNT_BITS-1:0] node_rtotal;
  logic [COUNT_BITS-1:0] node_rfinal;
  logic [COUNT_BITS-1:0] edge_rcount;
  logic [NODE_W-1:0]     edge_rtarget;
  logic                  step_ok;
  logic                  end_ok;
  logic                  scl_start;
  logic [COUNT_BITS-1:0] scl_count;
  logic                  scl_done;
  logic [PROB_W-1:0]     scl_result;

  assign in_ready  = (state == S_IDLE) && cleared;
  assign cfg_ready = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // range checks on loads and on the walk
  assign load_node_ok = 32'(node_index) < NODE_COUNT;
  assign load_sym_ok  = 32'(symbol) < ALPHABET_SIZE;
  assign walk_node_ok = 32'(current_node) < NODE_COUNT;
  assign walk_sym_ok  = 32'(item_sym) < ALPHABET_SIZE;

  pdfa_tables #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_tables (
    .clk          (clk),
    .rst          (rst),
    .cleared      (cleared),
    .node_we      (in_xfer && (mode_t'(mode) == MODE_LOAD_NODE) && load_node_ok),
    .node_waddr   (NA_W'(node_index)),
    .node_wtotal  (COUNT_BITS'(count_value)),
    .node_wfinal  (COUNT_BITS'(final_count)),
    .node_raddr   (NA_W'(current_node)),
    .node_rtotal  (node_rtotal),
    .node_rfinal  (node_rfinal),
    .edge_we      (in_xfer && (mode_t'(mode) == MODE_LOAD_EDGE) && load_node_ok
                   && load_sym_ok),
    .edge_waddr   (EA_W'(32'(node_index) * ALPHABET_SIZE + 32'(symbol))),
    .edge_wcount  (COUNT_BITS'(count_value)),
    .edge_wtarget (target_node),
    .edge_raddr   (EA_W'(32'(current_node) * ALPHABET_SIZE + 32'(symbol))),
    .edge_rcount  (edge_rcount),
    .edge_rtarget (edge_rtarget)
  );

  // decisions on the looked-up entries
  assign step_ok = !walk_failed && walk_node_ok && walk_sym_ok
                   && (edge_rcount != '0) && (node_rtotal != '0);
  assign end_ok  = !walk_failed && walk_node_ok
                   && (node_rtotal != '0) && (node_rfinal != '0);

  always_comb begin
    scl_start = 1'b0;
    scl_count = edge_rcount;
    if (state == S_LOOK) begin
      if (item_mode == MODE_END) begin
        scl_start = end_ok;
        scl_count = node_rfinal;
      end else begin
        scl_start = step_ok;
      end
    end
  end

  pdfa_scale_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .start    (scl_start),
    .prob_in  (running_prob),
    .count_in (scl_count),
    .size_in  (node_rtotal),
    .done     (scl_done),
    .result   (scl_result)
  );

  // sequencer, walk state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_node    <= '0;
      current_node <= '0;
      running_prob <= PROB_ONE;
      walk_failed  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            item_mode <= mode_t'(mode);
            item_sym  <= symbol;
            if ((mode_t'(mode) == MODE_SYMBOL) || (mode_t'(mode) == MODE_END)) begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          next_node <= edge_rtarget;
          if (item_mode == MODE_END) begin
            if (end_ok) begin
              state <= S_WAIT;
            end else begin
              res_prob     <= '0;
              res_rej      <= 1'b1;
              current_node <= root_node;
              running_prob <= PROB_ONE;
              walk_failed  <= 1'b0;
              state        <= S_EMIT;
            end
          end else if (step_ok) begin
            state <= S_WAIT;
          end else begin
            walk_failed <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (scl_done) begin
            if (item_mode == MODE_END) begin
              res_prob     <= scl_result;
              res_rej      <= 1'b0;
              current_node <= root_node;
              running_prob <= PROB_ONE;
              walk_failed  <= 1'b0;
              state        <= S_EMIT;
            end else begin
              running_prob <= scl_result;
              current_node <= next_node;
              state        <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            probability <= res_prob;
            rejected    <= res_rej;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // root write restarts the walk
      if (cfg_valid && cfg_ready) begin
        root_node    <= cfg_data;
        current_node <= cfg_data;
        running_prob <= PROB_ONE;
        walk_failed  <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/pdfa_tables.sv
module pdfa_tables
  import pdfa_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  localparam int EDGE_DEPTH   = NODE_COUNT * ALPHABET_SIZE,
  localparam int NA_W         = $clog2(NODE_COUNT),
  localparam int EA_W         = $clog2(EDGE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  cleared,
  input  logic                  node_we,
  input  logic [NA_W-1:0]       node_waddr,
  input  logic [COUNT_BITS-1:0] node_wtotal,
  input  logic [COUNT_BITS-1:0] node_wfinal,
  input  logic [NA_W-1:0]       node_raddr,
  output logic [COUNT_BITS-1:0] node_rtotal,
  output logic [COUNT_BITS-1:0] node_rfinal,
  input  logic                  edge_we,
  input  logic [EA_W-1:0]       edge_waddr,
  input  logic [COUNT_BITS-1:0] edge_wcount,
  input  logic [NODE_W-1:0]     edge_wtarget,
  input  logic [EA_W-1:0]       edge_raddr,
  output logic [COUNT_BITS-1:0] edge_rcount,
  output logic [NODE_W-1:0]     edge_rtarget
);

  logic [2*COUNT_BITS-1:0]       node_mem [NODE_COUNT];
  logic [NODE_W+COUNT_BITS-1:0]  edge_mem [EDGE_DEPTH];
  logic                          clearing;
  logic [EA_W-1:0]               clr_addr;

  // clearing pass over the edge counts after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == EA_W'(EDGE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign cleared = !clearing;

  // node table: total and final counts
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= {node_wtotal, node_wfinal};
    end
    {node_rtotal, node_rfinal} <= node_mem[node_raddr];
  end

  // edge table: target and count, cleared to no edges
  always_ff @(posedge clk) begin
    if (clearing) begin
      edge_mem[clr_addr] <= '0;
    end else if (edge_we) begin
      edge_mem[edge_waddr] <= {edge_wtarget, edge_wcount};
    end
    {edge_rtarget, edge_rcount} <= edge_mem[edge_raddr];
  end

endmodule

FILE: hdl/pdfa_scale_unit.sv
module pdfa_scale_unit
  import pdfa_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PROB_W-1:0]     prob_in,
  input  logic [COUNT_BITS-1:0] count_in,
  input  logic [COUNT_BITS-1:0] size_in,
  output logic                  done,
  output logic [PROB_W-1:0]     result
);

  localparam int PW     = PROB_W + COUNT_BITS;
  localparam int STEP_W = $clog2(PROB_W);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_CHK,
    U_DIV,
    U_FIN
  } ustate_t;

  ustate_t                   state;
  logic [PROB_W-1:0]         p_reg;
  logic [COUNT_BITS-1:0]     c_reg;
  logic [COUNT_BITS-1:0]     s_reg;
  logic [PW-1:0]             prod;
  logic [COUNT_BITS-1:0]     rem;
  logic [PROB_W-1:0]         dq;
  logic [STEP_W-1:0]         step;
  logic [32+COUNT_BITS-1:0]  mul_lo;
  logic [COUNT_BITS:0]       trial;
  logic [COUNT_BITS:0]       diff;
  logic                      ge;

  // low word product; a probability of exactly 1.0 is a plain shift
  assign mul_lo = p_reg[31:0] * c_reg;

  // one restoring division step
  assign trial = {rem, dq[PROB_W-1]};
  assign diff  = trial - {1'b0, s_reg};
  assign ge    = trial >= {1'b0, s_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (start) begin
            p_reg <= prob_in;
            c_reg <= count_in;
            s_reg <= size_in;
            state <= U_MUL;
          end
        end
        U_MUL: begin
          prod  <= p_reg[PROB_W-1] ? PW'({c_reg, 32'b0}) : PW'(mul_lo);
          state <= U_CHK;
        end
        U_CHK: begin
          // quotient of 2^33 or more saturates right away
          if (prod[PW-1:PROB_W] >= s_reg) begin
            result <= PROB_ONE;
            done   <= 1'b1;
            state  <= U_IDLE;
          end else begin
            rem   <= prod[PW-1:PROB_W];
            dq    <= prod[PROB_W-1:0];
            step  <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          rem  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
          dq   <= {dq[PROB_W-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_W'(PROB_W - 1)) begin
            state <= U_FIN;
          end
        end
        U_FIN: begin
          // clamp at 1.0
          result <= (dq[PROB_W-1] && (|dq[PROB_W-2:0])) ? PROB_ONE : dq;
          done   <= 1'b1;
          state  <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

FILE: test/pdfa_trace_scorer_tb.sv
module pdfa_trace_scorer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdfa_pkg::*;

  localparam int NODES        = NODE_COUNT_DEF;
  localparam int SYMS         = ALPHABET_SIZE_DEF;
  localparam int CORE_NODES   = 32;
  localparam int IDLE_PAUSE   = 64;
  localparam int STALL_LIMIT  = 20000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    mode_t             kind;
    logic [NODE_W-1:0] node;
    logic [SYM_W-1:0]  sym;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  fin;
    logic [NODE_W-1:0] tgt;
  } trace_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              rej;
  } score_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [NODE_W-1:0] node_index = '0;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CNT_W-1:0]  count_value = '0;
  logic [CNT_W-1:0]  final_count = '0;
  logic [NODE_W-1:0] target_node = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PROB_W-1:0] probability;
  logic              rejected;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_data = '0;

  // automaton tables and walk state as the scorer should hold them
  logic [CNT_W-1:0]  node_total_m [NODES];
  logic [CNT_W-1:0]  node_final_m [NODES];
  logic [CNT_W-1:0]  edge_count_m [NODES][SYMS];
  logic [NODE_W-1:0] edge_target_m [NODES][SYMS];
  logic [NODE_W-1:0] root_reg;
  logic [NODE_W-1:0] walk_node;
  logic [PROB_W-1:0] walk_prob;
  logic              walk_rejected;

  score_t expected_scores[$];
  int     mismatches = 0;
  int     stall_cycles = 0;
  int     items_sent = 0;
  int     send_gap_pct = 25;
  int     recv_gap_pct = 67;

  always #6 clk = ~clk;

  pdfa_trace_scorer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .node_index  (node_index),
    .symbol      (symbol),
    .count_value (count_value),
    .final_count (final_count),
    .target_node (target_node),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .probability (probability),
    .rejected    (rejected),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // floor(p * num / den), capped at 1.0
  function automatic logic [PROB_W-1:0] scaled_prob(input logic [PROB_W-1:0] p,
                                                    input logic [CNT_W-1:0] num,
                                                    input logic [CNT_W-1:0] den);
    logic [63:0] wide;
    wide = 64'(p) * 64'(num) / 64'(den);
    if (wide > 64'(PROB_ONE)) return PROB_ONE;
    return wide[PROB_W-1:0];
  endfunction

  function automatic void restart_walk();
    walk_node     = root_reg;
    walk_prob     = PROB_ONE;
    walk_rejected = 1'b0;
  endfunction

  // advance the expected walk by one accepted item
  function automatic void score_item(input trace_item_t it);
    score_t res;
    case (it.kind)
      MODE_LOAD_NODE: begin
        node_total_m[it.node] = it.cnt;
        node_final_m[it.node] = it.fin;
      end
      MODE_LOAD_EDGE: begin
        edge_count_m[it.node][it.sym]  = it.cnt;
        edge_target_m[it.node][it.sym] = it.tgt;
      end
      MODE_SYMBOL: begin
        if (!walk_rejected) begin
          if (edge_count_m[walk_node][it.sym] == '0 || node_total_m[walk_node] == '0) begin
            walk_rejected = 1'b1;
          end else begin
            walk_prob = scaled_prob(walk_prob, edge_count_m[walk_node][it.sym],
                                    node_total_m[walk_node]);
            walk_node = edge_target_m[walk_node][it.sym];
          end
        end
      end
      default: begin
        res.prob = '0;
        res.rej  = 1'b1;
        if (!walk_rejected && node_total_m[walk_node] != '0 &&
            node_final_m[walk_node] != '0) begin
          res.prob = scaled_prob(walk_prob, node_final_m[walk_node], node_total_m[walk_node]);
          res.rej  = 1'b0;
        end
        expected_scores.insert(expected_scores.size(), res);
        restart_walk();
      end
    endcase
  endfunction

  function automatic trace_item_t noise_item(input mode_t kind);
    trace_item_t it;
    it.kind = kind;
    it.node = NODE_W'($urandom());
    it.sym  = SYM_W'($urandom());
    it.cnt  = CNT_W'($urandom());
    it.fin  = CNT_W'($urandom());
    it.tgt  = NODE_W'($urandom());
    return it;
  endfunction

  // mostly nodes of a small dense core so that walks run deep
  function automatic logic [NODE_W-1:0] pick_node(input int core_pct);
    if ($urandom_range(99) < core_pct) return NODE_W'($urandom_range(CORE_NODES - 1));
    return NODE_W'($urandom());
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return CNT_W'(1);
    if (sel < 15) return '1;
    if (sel < 60) return CNT_W'($urandom_range(1000, 1));
    return CNT_W'($urandom());
  endfunction

  // edge count relative to the node size: removed, equal, above, or a share
  function automatic logic [CNT_W-1:0] pick_edge_count(input logic [CNT_W-1:0] total);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (total == '0) return pick_count();
    if (sel < 28) return total;
    if (sel < 36) return '1;
    return CNT_W'($urandom_range(total, 1));
  endfunction

  // one input transfer with random gaps before it
  task automatic send_item(input trace_item_t it);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= it.kind;
    node_index  <= it.node;
    symbol      <= it.sym;
    count_value <= it.cnt;
    final_count <= it.fin;
    target_node <= it.tgt;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    score_item(it);
  endtask

  task automatic send_node(input logic [NODE_W-1:0] n, input logic [CNT_W-1:0] total,
                           input logic [CNT_W-1:0] fin);
    trace_item_t it;
    it      = noise_item(MODE_LOAD_NODE);
    it.node = n;
    it.cnt  = total;
    it.fin  = fin;
    send_item(it);
  endtask

  task automatic send_edge(input logic [NODE_W-1:0] n, input logic [SYM_W-1:0] s,
                           input logic [CNT_W-1:0] c, input logic [NODE_W-1:0] t);
    trace_item_t it;
    it      = noise_item(MODE_LOAD_EDGE);
    it.node = n;
    it.sym  = s;
    it.cnt  = c;
    it.tgt  = t;
    send_item(it);
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] s);
    trace_item_t it;
    it     = noise_item(MODE_SYMBOL);
    it.sym = s;
    send_item(it);
  endtask

  task automatic send_end();
    send_item(noise_item(MODE_END));
  endtask

  // drain all scores, then let a pending symbol finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_scores.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_root(input logic [NODE_W-1:0] root);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= root;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    root_reg = root;
    restart_walk();
  endtask

  task automatic test_directed_cases();
    // empty trace at the root after reset
    send_node(8'd0, 24'd10, 24'd5);
    send_end();
    // edge count equal to size, final equal to size: exactly 1.0
    send_node(8'hFF, '1, '1);
    send_edge(8'd0, 4'hF, 24'd10, 8'hFF);
    send_symbol(4'hF);
    send_end();
    // edge count above the node size saturates at 1.0
    send_edge(8'd0, 4'd1, '1, 8'd0);
    send_symbol(4'd1);
    send_symbol(4'd1);
    send_end();
    // missing edge rejects, later symbols are ignored
    send_symbol(4'd2);
    send_symbol(4'hF);
    send_end();
    // zero final count at the end
    send_node(8'd1, 24'd7, 24'd0);
    send_edge(8'd0, 4'd3, 24'd3, 8'd1);
    send_symbol(4'd3);
    send_end();
    // zero node size on a symbol and at the end
    send_node(8'd2, 24'd0, 24'd4);
    send_edge(8'd0, 4'd4, 24'd1, 8'd2);
    send_symbol(4'd4);
    send_symbol(4'd0);
    send_end();
    send_symbol(4'd4);
    send_end();
    // edge removed by a zero count
    send_edge(8'd0, 4'd1, 24'd0, 8'd0);
    send_symbol(4'd1);
    send_end();
  endtask

  task automatic test_root_register();
    write_root(8'hFF);
    send_end();
    send_edge(8'hFF, 4'd7, 24'd1, 8'd0);
    send_symbol(4'd7);
    send_end();
    // a root write in the middle of a walk restarts it
    send_symbol(4'd7);
    write_root(8'd0);
    send_end();
    write_root(8'd1);
    send_end();
    write_root(8'd0);
  endtask

  task automatic test_build_automaton();
    logic [NODE_W-1:0] n;
    for (int k = 0; k < NODES; k++) send_node(NODE_W'(k), pick_count(), pick_count());
    repeat (320) begin
      n = pick_node(75);
      send_edge(n, SYM_W'($urandom()), pick_edge_count(node_total_m[n]), pick_node(85));
    end
  endtask

  task automatic test_random_traces(input int n_items);
    int                goal;
    int                len;
    logic [NODE_W-1:0] n;
    logic [SYM_W-1:0]  live[$];
    goal = items_sent + n_items;
    write_root(pick_node(90));
    while (items_sent < goal) begin
      len = $urandom_range(8);
      repeat (len) begin
        // occasional loads and root writes in the middle of a walk
        if ($urandom_range(199) == 0) write_root(pick_node(90));
        case ($urandom_range(24))
          0: send_node(pick_node(70), pick_count(), pick_count());
          1: begin
            n = pick_node(75);
            send_edge(n, SYM_W'($urandom()), pick_edge_count(node_total_m[n]), pick_node(85));
          end
          default: ;
        endcase
        live = {};
        for (int k = 0; k < SYMS; k++) begin
          if (edge_count_m[walk_node][k] != '0) live.insert(live.size(), SYM_W'(k));
        end
        if (live.size() != 0 && $urandom_range(99) < 88)
          send_symbol(live[$urandom_range(live.size() - 1)]);
        else
          send_symbol(SYM_W'($urandom()));
      end
      send_end();
    end
  endtask

  // score check, receiver stalls and watchdog
  always @(posedge clk) begin : check_scores
    score_t want;
    if (out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected score: probability %h rejected %b", probability, rejected);
      end else begin
        want = expected_scores.pop_front();
        if (probability !== want.prob || rejected !== want.rej) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("score mismatch: expected probability %h rejected %b, got %h %b",
                     want.prob, want.rej, probability, rejected);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    out_ready <= (recv_gap_pct == 0) || ($urandom_range(99) >= recv_gap_pct);
  end

  initial begin
    for (int n = 0; n < NODES; n++) begin
      for (int s = 0; s < SYMS; s++) edge_count_m[n][s] = '0;
    end
    root_reg = '0;
    restart_walk();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_root_register();
    test_build_automaton();
    test_random_traces(360);
    send_gap_pct = 67;
    recv_gap_pct = 25;
    test_random_traces(370);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traces(370);
    wait_idle();

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: pdfa_trace_scorer.f
hdl/pdfa_pkg.sv
hdl/pdfa_tables.sv
hdl/pdfa_scale_unit.sv
hdl/pdfa_trace_scorer.sv
test/pdfa_trace_scorer_tb.sv
